>>> sv/pdl_pkg.sv
// Shared constants, codes and types for the positional deque list.
`default_nettype none
package pdl_pkg;
	localparam int CAPACITY = 64;
	localparam int DATA_W   = 32;
	localparam int KIND_W   = 3;
	localparam int POS_W    = 8;
	localparam int LEN_W    = 7;
	localparam int STAT_W   = 2;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

	localparam logic [KIND_W-1:0] KIND_INS_FRONT = 3'd0;
	localparam logic [KIND_W-1:0] KIND_INS_END   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_INS_POS   = 3'd2;
	localparam logic [KIND_W-1:0] KIND_REM_FRONT = 3'd3;
	localparam logic [KIND_W-1:0] KIND_REM_END   = 3'd4;
	localparam logic [KIND_W-1:0] KIND_REM_POS   = 3'd5;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

	typedef struct packed {
		logic              ins;
		logic              rem;
		logic [CMP_W-1:0]  tgt;
		logic [DATA_W-1:0] value;
	} pdl_ctl_t;
endpackage
`default_nettype wire

>>> sv/pdl_req_if.sv
// Request channel: operation kind, value and position.
`default_nettype none
interface pdl_req_if;
	import pdl_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [KIND_W-1:0]        kind;
	logic signed [DATA_W-1:0] value;
	logic [POS_W-1:0]         position;

	modport source (output valid, kind, value, position, input ready);
	modport sink (input valid, kind, value, position, output ready);
endinterface
`default_nettype wire

>>> sv/pdl_rsp_if.sv
// Response channel: status, removed value and list length.
`default_nettype none
interface pdl_rsp_if;
	import pdl_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [STAT_W-1:0]        status;
	logic signed [DATA_W-1:0] removed_value;
	logic [LEN_W-1:0]         length;

	modport source (output valid, status, removed_value, length, input ready);
	modport sink (input valid, status, removed_value, length, output ready);
endinterface
`default_nettype wire

>>> sv/positional_deque_list.sv
// Positional deque list: a row of shifting cells with one response per request.
// The response to an accepted request is registered and shows in the next cycle.
// Throughput: one request per cycle while responses are taken; all shifting cells move in the same cycle.
// A response that is not taken holds off the next request until it leaves.
// Reset clears the length and the response valid; cell contents stay undefined.
`default_nettype none
module positional_deque_list (
	input  wire logic clk,
	input  wire logic arst_n,
	pdl_req_if.sink   req,
	pdl_rsp_if.source rsp
);
	import pdl_pkg::*;

	logic [CNT_W-1:0]  count_q;
	logic              rsp_valid_q;
	logic [STAT_W-1:0] status_q;
	logic [DATA_W-1:0] removed_q;
	logic [LEN_W-1:0]  length_q;

	logic              fire;
	logic              full;
	logic              empty;
	logic [CMP_W-1:0]  pos_ext;
	logic [CMP_W-1:0]  cnt_ext;
	logic              do_ins;
	logic              do_rem;
	logic [CMP_W-1:0]  tgt;
	logic [STAT_W-1:0] status;
	logic [CNT_W-1:0]  count_nxt;
	logic [DATA_W-1:0] removed;
	pdl_ctl_t          ctl;

	logic [DATA_W-1:0] vals [CAPACITY];
	logic [DATA_W-1:0] hits [CAPACITY];

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign fire      = req.valid && req.ready;
	assign full      = (count_q == CNT_W'(CAPACITY));
	assign empty     = (count_q == '0);
	assign pos_ext   = CMP_W'(req.position);
	assign cnt_ext   = CMP_W'(count_q);

	always_comb begin
		do_ins = 1'b0;
		do_rem = 1'b0;
		tgt    = '0;
		status = ST_OK;
		case (req.kind)
			KIND_INS_FRONT, KIND_INS_END, KIND_INS_POS: begin
				tgt = (req.kind == KIND_INS_FRONT) ? '0 :
				      (req.kind == KIND_INS_END) ? cnt_ext : pos_ext;
				if (full) begin
					status = ST_FULL;
				end else if (tgt > cnt_ext) begin
					status = ST_RANGE;
				end else begin
					do_ins = 1'b1;
				end
			end
			KIND_REM_FRONT, KIND_REM_END, KIND_REM_POS: begin
				tgt = (req.kind == KIND_REM_FRONT) ? '0 :
				      (req.kind == KIND_REM_END) ? cnt_ext - CMP_W'(1) : pos_ext;
				if (empty) begin
					status = ST_EMPTY;
				end else if (tgt >= cnt_ext) begin
					status = ST_RANGE;
				end else begin
					do_rem = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign ctl.ins   = fire && do_ins;
	assign ctl.rem   = fire && do_rem;
	assign ctl.tgt   = tgt;
	assign ctl.value = req.value;

	assign count_nxt = do_ins ? count_q + CNT_W'(1) :
	                   do_rem ? count_q - CNT_W'(1) : count_q;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		pdl_cell u_cell (
			.clk   (clk),
			.ctl   (ctl),
			.idx   (CMP_W'(i)),
			.left  ((i == 0) ? '0 : vals[(i == 0) ? 0 : i - 1]),
			.right ((i == CAPACITY - 1) ? '0 : vals[(i == CAPACITY - 1) ? i : i + 1]),
			.val   (vals[i]),
			.hit   (hits[i])
		);
	end

	always_comb begin
		removed = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			removed = removed | hits[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				count_q <= count_nxt;
			end
			if (fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_q  <= status;
			removed_q <= removed;
			length_q  <= LEN_W'(count_nxt);
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.status        = status_q;
	assign rsp.removed_value = removed_q;
	assign rsp.length        = length_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("list length above capacity");

	a_len_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> (rsp.length == LEN_W'(count_q)))
		else $error("response length differs from list length");

	a_empty_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && empty && (req.kind == KIND_REM_FRONT || req.kind == KIND_REM_END ||
		 req.kind == KIND_REM_POS)) |=> (rsp.status == ST_EMPTY && rsp.removed_value == '0))
		else $error("removal from empty list not flagged");

	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && full && (req.kind == KIND_INS_FRONT || req.kind == KIND_INS_END ||
		 req.kind == KIND_INS_POS)) |=> (count_q == CNT_W'(CAPACITY) && rsp.status == ST_FULL))
		else $error("insert into full list changed state");
`endif
endmodule
`default_nettype wire

>>> sv/pdl_cell.sv
// One list slot: holds a value and shifts toward either neighbor.
`default_nettype none
module pdl_cell (
	input  wire logic                      clk,
	input  wire pdl_pkg::pdl_ctl_t         ctl,
	input  wire logic [pdl_pkg::CMP_W-1:0] idx,
	input  wire logic [pdl_pkg::DATA_W-1:0] left,
	input  wire logic [pdl_pkg::DATA_W-1:0] right,
	output logic [pdl_pkg::DATA_W-1:0]      val,
	output logic [pdl_pkg::DATA_W-1:0]      hit
);
	import pdl_pkg::*;

	logic [DATA_W-1:0] val_q;

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (idx > ctl.tgt) begin
				val_q <= left;
			end else if (idx == ctl.tgt) begin
				val_q <= ctl.value;
			end
		end else if (ctl.rem) begin
			if (idx >= ctl.tgt) begin
				val_q <= right;
			end
		end
	end

	assign val = val_q;
	assign hit = (ctl.rem && idx == ctl.tgt) ? val_q : '0;
endmodule
`default_nettype wire
